### src/cnh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnh_pkg
// Shared types, widths and a helper function for the circulant next-hop router.
// ----------------------------------------------------------------------------
package cnh_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int NODE_W      = 10;
  localparam int CNT_W       = 11;
  localparam int GEN_W       = 10;
  localparam int X_W         = 13;
  localparam int MAG_W       = 12;
  localparam int REM_W       = 10;
  localparam int COST_W      = 14;
  localparam int STEP_W      = 11;
  localparam int LANES       = 6;
  localparam int DIV_BPS     = 3;
  localparam int DIV_STAGES  = MAG_W / DIV_BPS;
  localparam int CFG_ADDR_W  = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NODES = 2'd0,
    CFG_GEN1  = 2'd1,
    CFG_GEN2  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic              swap;
  } side_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] quo;
    logic [REM_W-1:0] rem;
  } lane_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                              input logic             nbit,
                                              input logic [GEN_W-1:0] dv);
    logic [REM_W:0] t;
    logic [REM_W:0] d;
    begin
      t = {rem, nbit};
      d = {1'b0, dv};
      if (t >= d) begin
        div_step = {1'b1, REM_W'(t - d)};
      end else begin
        div_step = {1'b0, t[REM_W-1:0]};
      end
    end
  endfunction

endpackage
`default_nettype wire

### src/circulant_adaptive_next_hop.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circulant_adaptive_next_hop
// Next-hop router for a two-generator circulant ring.
// ----------------------------------------------------------------------------
// The block takes one source/target pair per cycle and returns the neighbor
// to forward to, together with the signed generator step. The pair passes
// through the operand stage, the four-stage divider by generator_2, run on six
// operands in parallel, and the estimate, choice and output stages.
// When the result side stalls, the whole pipeline holds and in_tready drops.
// Configuration writes take effect at once; the user must make them while no
// transfer is in flight, as the block itself does not enforce this.
module circulant_adaptive_next_hop
  import cnh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,   // source_id, target_id, zero pad
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [23:0]                out_tdata,  // next_id, hop_step, zero pad
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CNT_W-1:0]      cfg_wdata
);

  logic [CNT_W-1:0] nodes_r;
  logic [GEN_W-1:0] gen1_r;
  logic [GEN_W-1:0] gen2_r;
  logic [GEN_W-1:0] divisor;
  logic             adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r <= CNT_W'(16);
      gen1_r  <= GEN_W'(1);
      gen2_r  <= GEN_W'(4);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_NODES: nodes_r <= (cfg_wdata > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : cfg_wdata;
        CFG_GEN1:  gen1_r  <= cfg_wdata[GEN_W-1:0];
        CFG_GEN2:  gen2_r  <= cfg_wdata[GEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign divisor   = (gen2_r == '0) ? GEN_W'(1) : gen2_r;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  logic  f_valid;
  lane_t f_lane [LANES];
  side_t f_side;
  logic  d_valid;
  lane_t d_lane [LANES];
  side_t d_side;
  logic [NODE_W-1:0] next_id;
  logic [STEP_W-1:0] hop_step;

  cnh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_tvalid),
    .source_id   (in_tdata[NODE_W-1:0]),
    .target_id   (in_tdata[2*NODE_W-1:NODE_W]),
    .ring_size   (nodes_r),
    .out_valid   (f_valid),
    .out_lane    (f_lane),
    .out_side    (f_side)
  );

  cnh_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_lane   (f_lane),
    .in_side   (f_side),
    .divisor   (divisor),
    .out_valid (d_valid),
    .out_lane  (d_lane),
    .out_side  (d_side)
  );

  cnh_select u_select (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (d_valid),
    .in_lane     (d_lane),
    .in_side     (d_side),
    .ring_size   (nodes_r),
    .chord_short (gen1_r),
    .chord_long  (gen2_r),
    .out_valid   (out_tvalid),
    .next_id     (next_id),
    .hop_step    (hop_step)
  );

  assign out_tdata = {3'b000, hop_step, next_id};

endmodule
`default_nettype wire

### src/cnh_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnh_front
// Orders the node pair and forms the six signed division operands.
// ----------------------------------------------------------------------------
module cnh_front
  import cnh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic [NODE_W-1:0] source_id,
  input  wire logic [NODE_W-1:0] target_id,
  input  wire logic [CNT_W-1:0]  ring_size,
  output logic                   out_valid,
  output lane_t                  out_lane [LANES],
  output side_t                  out_side
);

  logic              valid_r;
  lane_t             lane_r   [LANES];
  lane_t             lane_nxt [LANES];
  side_t             side_r;
  side_t             side_nxt;

  always_comb begin
    logic [NODE_W-1:0] lo;
    logic [NODE_W-1:0] hi;
    logic signed [X_W-1:0] sf;
    logic signed [X_W-1:0] sb;
    logic signed [X_W-1:0] n;
    logic signed [X_W-1:0] x;
    if (source_id > target_id) begin
      lo = target_id;
      hi = source_id;
    end else begin
      lo = source_id;
      hi = target_id;
    end
    n  = X_W'(signed'({1'b0, ring_size}));
    sf = X_W'(signed'({1'b0, hi - lo}));
    sb = n - sf;
    for (int k = 0; k < LANES; k++) begin
      x = ((k < 3) ? sf : sb) + X_W'(k % 3) * n;
      lane_nxt[k].neg = x[X_W-1];
      lane_nxt[k].mag = x[X_W-1] ? MAG_W'(-x) : MAG_W'(x);
      lane_nxt[k].quo = '0;
      lane_nxt[k].rem = '0;
    end
    side_nxt.src  = source_id;
    side_nxt.swap = source_id > target_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r <= lane_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_lane  = lane_r;
  assign out_side  = side_r;

endmodule
`default_nettype wire

### src/cnh_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnh_div
// Pipelined restoring divider for all operand lanes, three bits per stage.
// ----------------------------------------------------------------------------
module cnh_div
  import cnh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  lane_t                 in_lane [LANES],
  input  side_t                 in_side,
  input  wire logic [GEN_W-1:0] divisor,
  output logic                  out_valid,
  output lane_t                 out_lane [LANES],
  output side_t                 out_side
);

  logic  valid_r [DIV_STAGES];
  lane_t lane_r  [DIV_STAGES][LANES];
  side_t side_r  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    lane_t lane_nxt [LANES];
    logic  vin;
    side_t sin;

    always_comb begin
      logic [REM_W:0] st;
      int             idx;
      for (int k = 0; k < LANES; k++) begin
        lane_nxt[k] = (s == 0) ? in_lane[k] : lane_r[(s == 0) ? 0 : s-1][k];
        for (int j = 0; j < DIV_BPS; j++) begin
          idx = MAG_W - 1 - s * DIV_BPS - j;
          st  = div_step(lane_nxt[k].rem, lane_nxt[k].mag[idx], divisor);
          lane_nxt[k].rem      = st[REM_W-1:0];
          lane_nxt[k].quo[idx] = st[REM_W];
        end
      end
    end

    if (s == 0) begin : g_first
      assign vin = in_valid;
      assign sin = in_side;
    end else begin : g_next
      assign vin = valid_r[s-1];
      assign sin = side_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (adv) begin
        valid_r[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lane_r[s] <= lane_nxt;
        side_r[s] <= sin;
      end
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_lane  = lane_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule
`default_nettype wire

### src/cnh_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnh_select
// Hop estimates, direction and step choice, and ring wrap of the next node.
// ----------------------------------------------------------------------------
module cnh_select
  import cnh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  lane_t                  in_lane [LANES],
  input  side_t                  in_side,
  input  wire logic [CNT_W-1:0]  ring_size,
  input  wire logic [GEN_W-1:0]  chord_short,
  input  wire logic [GEN_W-1:0]  chord_long,
  output logic                   out_valid,
  output logic [NODE_W-1:0]      next_id,
  output logic [STEP_W-1:0]      hop_step
);

  // Estimate stage.
  logic                     e1_valid_r;
  logic signed [COST_W-1:0] a_r   [LANES];
  logic signed [COST_W-1:0] b_r   [LANES];
  logic signed [COST_W-1:0] a_nxt [LANES];
  logic signed [COST_W-1:0] b_nxt [LANES];
  logic [1:0]               rz_r;
  logic [1:0]               rz_nxt;
  side_t                    e1_side_r;

  always_comb begin
    logic signed [COST_W-1:0] q;
    logic signed [COST_W-1:0] r;
    for (int k = 0; k < LANES; k++) begin
      q = COST_W'(signed'({1'b0, in_lane[k].quo}));
      r = COST_W'(signed'({1'b0, in_lane[k].rem}));
      if (in_lane[k].neg) begin
        q = -q;
        r = -r;
      end
      a_nxt[k] = q + r;
      b_nxt[k] = q - r + COST_W'(signed'({1'b0, chord_long})) + COST_W'(1);
    end
    rz_nxt[0] = in_lane[0].rem == '0;
    rz_nxt[1] = in_lane[3].rem == '0;
  end

  // Side choice stage.
  logic                     e2_valid_r;
  logic signed [COST_W-1:0] cost_r   [2];
  logic signed [COST_W-1:0] cost_nxt [2];
  logic [1:0]               g1_r;
  logic [1:0]               g1_nxt;
  side_t                    e2_side_r;

  always_comb begin
    logic signed [COST_W-1:0] best;
    logic                     g1;
    int                       base;
    for (int s = 0; s < 2; s++) begin
      base = s * 3;
      if (rz_r[s]) begin
        best = a_r[base];
        g1   = 1'b0;
      end else if (a_r[base] < b_r[base]) begin
        best = a_r[base];
        g1   = 1'b1;
      end else begin
        best = b_r[base];
        g1   = 1'b0;
      end
      for (int k = 1; k < 3; k++) begin
        if (a_r[base+k] < best) begin
          best = a_r[base+k];
          g1   = 1'b0;
        end
        if (b_r[base+k] < best) begin
          best = b_r[base+k];
          g1   = 1'b0;
        end
      end
      cost_nxt[s] = best;
      g1_nxt[s]   = g1;
    end
  end

  // Output stage.
  logic                valid_r;
  logic [NODE_W-1:0]   next_r;
  logic [NODE_W-1:0]   next_nxt;
  logic [STEP_W-1:0]   hop_r;
  logic [STEP_W-1:0]   hop_nxt;

  always_comb begin
    logic                   use_g1;
    logic                   neg;
    logic [GEN_W-1:0]       mag;
    logic signed [X_W-1:0]  sum;
    logic signed [X_W-1:0]  n;
    if (cost_r[0] < cost_r[1]) begin
      use_g1 = g1_r[0];
      neg    = 1'b0;
    end else begin
      use_g1 = g1_r[1];
      neg    = 1'b1;
    end
    neg     = neg ^ e2_side_r.swap;
    mag     = use_g1 ? chord_short : chord_long;
    hop_nxt = neg ? STEP_W'(-{1'b0, mag}) : {1'b0, mag};
    n       = X_W'(signed'({1'b0, ring_size}));
    sum     = X_W'(signed'({1'b0, e2_side_r.src})) + X_W'(signed'(hop_nxt));
    if (sum >= n) begin
      sum = sum - n;
    end else if (sum < 0) begin
      sum = sum + n;
    end
    next_nxt = sum[NODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_valid_r <= 1'b0;
      e2_valid_r <= 1'b0;
      valid_r    <= 1'b0;
    end else if (adv) begin
      e1_valid_r <= in_valid;
      e2_valid_r <= e1_valid_r;
      valid_r    <= e2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      rz_r      <= rz_nxt;
      e1_side_r <= in_side;
      cost_r    <= cost_nxt;
      g1_r      <= g1_nxt;
      e2_side_r <= e1_side_r;
      next_r    <= next_nxt;
      hop_r     <= hop_nxt;
    end
  end

  assign out_valid = valid_r;
  assign next_id   = next_r;
  assign hop_step  = hop_r;

endmodule
`default_nettype wire

### dv/circulant_adaptive_next_hop_chk.sv
// ----------------------------------------------------------------------------
// circulant_adaptive_next_hop_chk
// Watches the input, result and configuration ports of the next-hop router,
// predicts the next node and signed step for every input transfer, and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module circulant_adaptive_next_hop_chk
  import cnh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [23:0]           in_tdata,   // source_id, target_id, zero pad
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [23:0]           out_tdata,  // next_id, hop_step, zero pad
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CNT_W-1:0]      cfg_wdata,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic [STEP_W-1:0] hop;
    logic [NODE_W-1:0] next;
  } route_t;

  route_t route_q[$];
  int ring_n;
  int chord_1;
  int chord_2;

  function automatic int side_step(input int s, output int cost);
    int dv, q, r, a, b, best, step;
    dv = (chord_2 == 0) ? 1 : chord_2;
    q = s / dv;
    r = s % dv;
    a = q + r;
    b = q - r + chord_2 + 1;
    if (r == 0) begin
      best = a;
      step = chord_2;
    end else if (a < b) begin
      best = a;
      step = chord_1;
    end else begin
      best = b;
      step = chord_2;
    end
    for (int k = 1; k <= 2; k++) begin
      q = (s + k * ring_n) / dv;
      r = (s + k * ring_n) % dv;
      a = q + r;
      b = q - r + chord_2 + 1;
      if (a < best) begin
        best = a;
        step = chord_2;
      end
      if (b < best) begin
        best = b;
        step = chord_2;
      end
    end
    cost = best;
    return step;
  endfunction

  function automatic int signed_step(input int lo, input int hi);
    int cf, cb, sf, sb;
    sf = side_step(hi - lo, cf);
    sb = side_step(lo - hi + ring_n, cb);
    if (cf < cb) return sf;
    return -sb;
  endfunction

  function automatic route_t route_of(input int src, input int tgt);
    route_t res;
    int hop, nxt;
    if (src > tgt) hop = -signed_step(tgt, src);
    else hop = signed_step(src, tgt);
    nxt = src + hop;
    if (nxt >= ring_n) nxt -= ring_n;
    else if (nxt < 0) nxt += ring_n;
    res.hop = hop[STEP_W-1:0];
    res.next = nxt[NODE_W-1:0];
    return res;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("route mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    route_t want;
    if (!rst_n) begin
      ring_n = 16;
      chord_1 = 1;
      chord_2 = 4;
      route_q.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_NODES: ring_n = (cfg_wdata > MAX_NODES) ? MAX_NODES : int'(cfg_wdata);
          CFG_GEN1:  chord_1 = int'(cfg_wdata[GEN_W-1:0]);
          CFG_GEN2:  chord_2 = int'(cfg_wdata[GEN_W-1:0]);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        route_q = {route_q, route_of(int'(in_tdata[9:0]), int'(in_tdata[19:10]))};
      if (out_tvalid && out_tready) begin
        if (route_q.size() == 0) begin
          report("unexpected transfer", int'(out_tdata[9:0]), -1);
        end else begin
          want = route_q.pop_front();
          if (out_tdata[9:0] !== want.next)
            report("next_id", int'(out_tdata[9:0]), int'(want.next));
          if (out_tdata[20:10] !== want.hop)
            report("hop_step", int'($signed(out_tdata[20:10])), int'($signed(want.hop)));
          if (out_tdata[23:21] !== 3'b000)
            report("pad bits", int'(out_tdata[23:21]), 0);
        end
      end
      pending = route_q.size();
    end
  end

endmodule

### dv/circulant_adaptive_next_hop_tb.sv
// ----------------------------------------------------------------------------
// circulant_adaptive_next_hop_tb
// Drives source/target pairs through the circulant next-hop router under a
// series of ring and chord settings, with random gaps and back-pressure, and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module circulant_adaptive_next_hop_tb;
  import cnh_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CNT_W-1:0]      cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    cycles;
  bit                    calm;
  int                    ring_n;

  circulant_adaptive_next_hop DUT (.*);

  circulant_adaptive_next_hop_chk u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
        out_tready <= 1'b1;
      end
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  task automatic send_pair(input int src, input int tgt);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, tgt[9:0], src[9:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_ring(input int n, input int g1, input int g2);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_NODES;
    cfg_wdata <= n[CNT_W-1:0];
    @(negedge clk);
    cfg_addr <= CFG_GEN1;
    cfg_wdata <= g1[CNT_W-1:0];
    @(negedge clk);
    cfg_addr <= CFG_GEN2;
    cfg_wdata <= g2[CNT_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ring_n = (n > MAX_NODES) ? MAX_NODES : n;
  endtask

  task automatic random_pairs(input int count);
    int src, tgt;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        src = $urandom_range(0, 1023);
        tgt = $urandom_range(0, 1023);
      end else begin
        src = $urandom_range(0, ring_n - 1);
        tgt = ($urandom_range(0, 9) == 0) ? src : $urandom_range(0, ring_n - 1);
      end
      if (i % 100 == 0) calm = ($urandom_range(0, 2) == 0);
      send_pair(src, tgt);
    end
    calm = 1'b0;
  endtask

  initial begin
    int n, g1, g2;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_addr = CFG_NODES;
    cfg_wdata = '0;
    calm = 1'b0;
    ring_n = 16;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pair(0, 0);
    send_pair(0, 15);
    send_pair(15, 0);
    send_pair(3, 11);
    send_pair(11, 3);
    send_pair(7, 8);
    send_pair(8, 4);
    send_pair(1023, 1023);
    send_pair(1023, 0);
    send_pair(0, 1023);
    send_pair(5, 600);

    write_ring(1024, 1023, 1023);
    send_pair(0, 1023);
    send_pair(1023, 0);
    send_pair(512, 512);
    send_pair(682, 341);
    random_pairs(120);

    write_ring(2, 1, 1);
    send_pair(0, 1);
    send_pair(1, 0);
    send_pair(1023, 1);
    random_pairs(40);

    write_ring(2047, 1, 2);
    random_pairs(150);

    write_ring(100, 7, 0);
    send_pair(0, 99);
    random_pairs(60);

    write_ring(1024, 1, 1);
    random_pairs(100);

    for (int p = 0; p < 7; p++) begin
      n = $urandom_range(3, 1024);
      g1 = $urandom_range(1, n - 2);
      g2 = $urandom_range(g1, (n - 1 > 1023) ? 1023 : n - 1);
      write_ring(n, g1, g2);
      random_pairs(110);
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
